/* rtl/tsle_pkg.sv */
// Shared types and constants for the timeline signal layer evaluator.
// No dependencies; every other file refers to this package by scoped names.
package tsle_pkg;

    localparam int FRAME_W     = 31;
    localparam int VALUE_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUO_W       = 16;
    localparam int DIV_W       = 33;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SOURCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH  = 3'd7;

    localparam logic signed [VALUE_W-1:0] ONE_Q16 = 32'sd65536;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_TRIG   = 2'd2,
        CMD_EVAL   = 2'd3
    } t_cmd_kind;

    // pos carries the key position for an append, the local frame for an eval
    typedef struct packed {
        t_cmd_kind                   kind;
        logic [FRAME_W-1:0]          pos;
        logic signed [VALUE_W-1:0]   level;
    } t_cmd;

    typedef struct packed {
        logic                        layer_mode;
        logic [FRAME_W-1:0]          start_frame;
        logic [FRAME_W-1:0]          span_length;
        logic                        value_source;
        logic signed [VALUE_W-1:0]   source_low;
        logic signed [VALUE_W-1:0]   source_high;
        logic signed [VALUE_W-1:0]   target_low;
        logic signed [VALUE_W-1:0]   target_high;
    } t_cfg;

endpackage

/* rtl/tsle_req_if.sv */
// Request channel of the evaluator: valid/ready plus one input item.
// Depends on tsle_pkg for field widths.
interface tsle_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           op;
    logic [tsle_pkg::FRAME_W-1:0]         previous_frame;
    logic [tsle_pkg::FRAME_W-1:0]         current_frame;
    logic                                 is_playing;
    logic                                 at_break;
    logic [tsle_pkg::FRAME_W-1:0]         key_position;
    logic signed [tsle_pkg::VALUE_W-1:0]  key_level;

    modport source(output valid, op, previous_frame, current_frame, is_playing, at_break,
                   key_position, key_level, input ready);
    modport sink(input valid, op, previous_frame, current_frame, is_playing, at_break,
                 key_position, key_level, output ready);
endinterface

/* rtl/tsle_rsp_if.sv */
// Result channel of the evaluator: valid/ready plus one result item.
// Depends on tsle_pkg for field widths.
interface tsle_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 emit_kind;
    logic signed [tsle_pkg::VALUE_W-1:0]  signal_value;

    modport source(output valid, emit_kind, signal_value, input ready);
    modport sink(input valid, emit_kind, signal_value, output ready);
endinterface

/* rtl/tsle_front.sv */
// Front end: accepts requests, runs trigger / frame-dedup decisions, issues commands.
// Depends on tsle_pkg and tsle_req_if.
module tsle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsle_pkg::t_cfg  i_cfg,
    tsle_req_if.sink        i_req,
    input  logic            i_full,
    output logic            o_push,
    output tsle_pkg::t_cmd  o_cmd
);
    logic                          r_armed, n_armed;
    logic [tsle_pkg::FRAME_W-1:0]  r_last_frame, n_last_frame;
    logic                          r_last_valid, n_last_valid;
    logic                          accept;
    logic [tsle_pkg::FRAME_W:0]    span_end;
    logic                          before_start;
    logic                          in_span;

    // no request is taken while reset is held
    assign i_req.ready  = i_rst_n && !i_full;
    assign accept       = i_req.valid && i_rst_n && !i_full;
    assign span_end     = {1'b0, i_cfg.start_frame} + {1'b0, i_cfg.span_length};
    assign before_start = i_req.current_frame < i_cfg.start_frame;
    assign in_span      = !before_start && ({1'b0, i_req.current_frame} < span_end);

    always_comb begin
        n_armed      = r_armed;
        n_last_frame = r_last_frame;
        n_last_valid = r_last_valid;
        o_push       = 1'b0;
        o_cmd.kind   = tsle_pkg::CMD_CLEAR;
        o_cmd.pos    = i_req.key_position;
        o_cmd.level  = i_req.key_level;
        if (accept) begin
            case (i_req.op)
                tsle_pkg::OP_APPEND: begin
                    o_push     = 1'b1;
                    o_cmd.kind = tsle_pkg::CMD_APPEND;
                end
                tsle_pkg::OP_CLEAR: begin
                    o_push     = 1'b1;
                    o_cmd.kind = tsle_pkg::CMD_CLEAR;
                end
                tsle_pkg::OP_TICK: begin
                    if (!i_cfg.layer_mode) begin
                        // re-arm while parked before start; fire on forward crossing
                        if (i_req.is_playing && !i_req.at_break && !before_start
                            && (i_req.previous_frame < i_cfg.start_frame)
                            && (before_start || r_armed)) begin
                            n_armed    = 1'b0;
                            o_push     = 1'b1;
                            o_cmd.kind = tsle_pkg::CMD_TRIG;
                        end else if (before_start) begin
                            n_armed = 1'b1;
                        end
                    end else if (in_span && i_req.is_playing && !i_req.at_break
                                 && !(r_last_valid
                                      && r_last_frame == i_req.current_frame)) begin
                        n_last_frame = i_req.current_frame;
                        n_last_valid = 1'b1;
                        o_push       = 1'b1;
                        o_cmd.kind   = tsle_pkg::CMD_EVAL;
                        o_cmd.pos    = i_req.current_frame - i_cfg.start_frame;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b1;
            r_last_frame <= '0;
            r_last_valid <= 1'b0;
        end else begin
            r_armed      <= n_armed;
            r_last_frame <= n_last_frame;
            r_last_valid <= n_last_valid;
        end
    end
endmodule

/* rtl/tsle_queue.sv */
// Short command queue between front end and back end.
// Depends on tsle_pkg.
module tsle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tsle_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output tsle_pkg::t_cmd  o_cmd,
    output logic            o_full,
    output logic            o_empty
);
    tsle_pkg::t_cmd                r_slot [tsle_pkg::QUEUE_DEPTH];
    logic [tsle_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [tsle_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = r_cnt == tsle_pkg::QCNT_W'(tsle_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* rtl/tsle_div.sv */
// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den).
// Requires num < den. Depends on tsle_pkg.
module tsle_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tsle_pkg::DIV_W-1:0]   i_num,
    input  logic [tsle_pkg::DIV_W-1:0]   i_den,
    output logic                         o_done,
    output logic [tsle_pkg::QUO_W-1:0]   o_quo
);
    logic                          r_busy;
    logic                          r_done;
    logic [4:0]                    r_cnt;
    logic [tsle_pkg::DIV_W-1:0]    r_rem;
    logic [tsle_pkg::DIV_W-1:0]    r_den;
    logic [tsle_pkg::QUO_W-1:0]    r_quo;
    logic [tsle_pkg::DIV_W:0]      shifted;
    logic                          fits;

    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? tsle_pkg::DIV_W'(shifted - {1'b0, r_den})
                          : tsle_pkg::DIV_W'(shifted);
            r_quo <= {r_quo[tsle_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(tsle_pkg::QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/tsle_back.sv */
// Back end: keyframe table, keyframe search, interpolation, range map, result register.
// Depends on tsle_pkg, tsle_div and tsle_rsp_if.
module tsle_back #(
    parameter int MAX_KEYS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsle_pkg::t_cfg  i_cfg,
    input  tsle_pkg::t_cmd  i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    tsle_rsp_if.source      o_rsp
);
    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int VW = tsle_pkg::VALUE_W;
    localparam int FW = tsle_pkg::FRAME_W;
    localparam int PW = 51;
    localparam logic [tsle_pkg::QUO_W:0] ONE_Q16_U = 17'h1_0000;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_PDIV = 11'b000_0000_0010,
        S_KRD  = 11'b000_0000_0100,
        S_KCHK = 11'b000_0000_1000,
        S_KDIV = 11'b000_0001_0000,
        S_KMUL = 11'b000_0010_0000,
        S_MAP  = 11'b000_0100_0000,
        S_MDIV = 11'b000_1000_0000,
        S_MMUL = 11'b001_0000_0000,
        S_MADD = 11'b010_0000_0000,
        S_PUT  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LAST  = 2'd1,
        PH_SCAN  = 2'd2
    } t_phase;

    logic [FW+VW-1:0]          r_mem [MAX_KEYS];
    logic [FW+VW-1:0]          r_rd;

    t_state                    r_state, n_state;
    t_phase                    r_phase, n_phase;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_idx, n_idx;
    logic [FW-1:0]             r_local, n_local;
    logic [FW-1:0]             r_p0, n_p0;
    logic signed [VW-1:0]      r_l0, n_l0;
    logic signed [VW-1:0]      r_l1, n_l1;
    logic signed [VW-1:0]      r_raw, n_raw;
    logic signed [PW-1:0]      r_prod, n_prod;
    logic [tsle_pkg::QUO_W:0]  r_t, n_t;
    logic                      r_kind, n_kind;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_kind, n_out_kind;
    logic signed [VW-1:0]      r_out_val, n_out_val;

    logic                           mem_we;
    logic                           div_start;
    logic [tsle_pkg::DIV_W-1:0]     div_num, div_den;
    logic                           div_done;
    logic [tsle_pkg::QUO_W-1:0]     div_quo;

    logic [FW-1:0]             rd_pos;
    logic signed [VW-1:0]      rd_lev;
    logic signed [VW:0]        lev_diff;
    logic signed [VW:0]        map_num, map_den, tgt_diff;
    logic [VW:0]               map_an, map_ad;
    logic signed [PW-1:0]      prod_trunc;

    assign rd_pos   = r_rd[FW+VW-1:VW];
    assign rd_lev   = signed'(r_rd[VW-1:0]);
    assign lev_diff = {r_l1[VW-1], r_l1} - {r_l0[VW-1], r_l0};
    assign map_num  = {r_raw[VW-1], r_raw} - {i_cfg.source_low[VW-1], i_cfg.source_low};
    assign map_den  = {i_cfg.source_high[VW-1], i_cfg.source_high}
                    - {i_cfg.source_low[VW-1], i_cfg.source_low};
    assign tgt_diff = {i_cfg.target_high[VW-1], i_cfg.target_high}
                    - {i_cfg.target_low[VW-1], i_cfg.target_low};
    assign map_an   = map_num[VW] ? unsigned'(-map_num) : unsigned'(map_num);
    assign map_ad   = map_den[VW] ? unsigned'(-map_den) : unsigned'(map_den);
    // divide by 2^16 rounding toward zero
    assign prod_trunc = (r_prod + (r_prod[PW-1] ? PW'(65535) : PW'(0))) >>> 16;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.emit_kind    = r_out_kind;
    assign o_rsp.signal_value = r_out_val;

    tsle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_idx       = r_idx;
        n_local     = r_local;
        n_p0        = r_p0;
        n_l0        = r_l0;
        n_l1        = r_l1;
        n_raw       = r_raw;
        n_prod      = r_prod;
        n_t         = r_t;
        n_kind      = r_kind;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        div_num     = map_an;
        div_den     = map_ad;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_local = i_cmd.pos;
                    case (i_cmd.kind)
                        tsle_pkg::CMD_APPEND: begin
                            if (r_count < CW'(MAX_KEYS)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        tsle_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        tsle_pkg::CMD_TRIG: begin
                            n_kind  = 1'b0;
                            n_state = S_PUT;
                        end
                        default: begin
                            n_kind = 1'b1;
                            if (!i_cfg.value_source) begin
                                div_start = 1'b1;
                                div_num   = tsle_pkg::DIV_W'(i_cmd.pos);
                                div_den   = tsle_pkg::DIV_W'(i_cfg.span_length);
                                n_state   = S_PDIV;
                            end else if (r_count == '0) begin
                                n_raw   = '0;
                                n_state = S_MAP;
                            end else begin
                                n_idx   = '0;
                                n_phase = PH_FIRST;
                                n_state = S_KRD;
                            end
                        end
                    endcase
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    n_raw   = VW'(div_quo);
                    n_state = S_MAP;
                end
            end
            S_KRD: begin
                n_state = S_KCHK;
            end
            S_KCHK: begin
                case (r_phase)
                    PH_FIRST: begin
                        n_p0 = rd_pos;
                        n_l0 = rd_lev;
                        if (r_local <= rd_pos) begin
                            n_raw   = rd_lev;
                            n_state = S_MAP;
                        end else begin
                            n_idx   = IW'(r_count - 1'b1);
                            n_phase = PH_LAST;
                            n_state = S_KRD;
                        end
                    end
                    PH_LAST: begin
                        if (r_local >= rd_pos) begin
                            n_raw   = rd_lev;
                            n_state = S_MAP;
                        end else begin
                            n_idx   = IW'(1);
                            n_phase = PH_SCAN;
                            n_state = S_KRD;
                        end
                    end
                    default: begin
                        if ((CW'(r_idx) == r_count - 1'b1) || (rd_pos >= r_local)) begin
                            if (rd_pos == r_local) begin
                                n_raw   = rd_lev;
                                n_state = S_MAP;
                            end else if (rd_pos <= r_p0 || r_local < r_p0) begin
                                n_raw   = r_l0;
                                n_state = S_MAP;
                            end else begin
                                n_l1      = rd_lev;
                                div_start = 1'b1;
                                div_num   = tsle_pkg::DIV_W'(r_local - r_p0);
                                div_den   = tsle_pkg::DIV_W'(rd_pos - r_p0);
                                n_state   = S_KDIV;
                            end
                        end else begin
                            n_p0    = rd_pos;
                            n_l0    = rd_lev;
                            n_idx   = r_idx + 1'b1;
                            n_state = S_KRD;
                        end
                    end
                endcase
            end
            S_KDIV: begin
                if (div_done) begin
                    n_prod  = PW'(lev_diff) * PW'(signed'({1'b0, div_quo}));
                    n_state = S_KMUL;
                end
            end
            S_KMUL: begin
                n_raw   = r_l0 + VW'(prod_trunc);
                n_state = S_MAP;
            end
            S_MAP: begin
                if (i_cfg.source_high == i_cfg.source_low) begin
                    n_t       = '0;
                    n_prod    = '0;
                    n_state   = S_MADD;
                end else if (map_num == '0 || map_num[VW] != map_den[VW]) begin
                    n_t     = '0;
                    n_state = S_MMUL;
                end else if (map_an >= map_ad) begin
                    n_t     = (tsle_pkg::QUO_W + 1)'(ONE_Q16_U);
                    n_state = S_MMUL;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_MDIV;
                end
            end
            S_MDIV: begin
                if (div_done) begin
                    n_t     = {1'b0, div_quo};
                    n_state = S_MMUL;
                end
            end
            S_MMUL: begin
                n_prod  = PW'(tgt_diff) * PW'(signed'({1'b0, r_t}));
                n_state = S_MADD;
            end
            S_MADD: begin
                n_raw   = i_cfg.target_low + VW'(prod_trunc);
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_val   = r_kind ? r_raw : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= {i_cmd.pos, i_cmd.level};
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_local   <= n_local;
        r_p0      <= n_p0;
        r_l0      <= n_l0;
        r_l1      <= n_l1;
        r_raw     <= n_raw;
        r_prod    <= n_prod;
        r_t       <= n_t;
        r_kind    <= n_kind;
        r_out_kind <= n_out_kind;
        r_out_val <= n_out_val;
        r_idx     <= n_idx;
        r_phase   <= n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* rtl/timeline_signal_layer_evaluator_unit.sv */
// Top level of the timeline signal layer evaluator: config registers, front end,
// command queue and back end. Depends on tsle_pkg, both channel interfaces and all tsle_ modules.
//
// One signal layer is evaluated per tick request. Momentary mode (layer_mode 0) gives a
// single trigger result (emit_kind 0, value 0) when the playhead crosses start_frame
// moving forward while playing and not at a break, and re-arms whenever the playhead is
// before the start. Continuous mode (layer_mode 1) gives one value per distinct frame
// inside [start_frame, start_frame+span_length): either the span progress or a linear
// interpolation over the keyframe table, then a clamped range map, all Q16.16.
// Append and clear requests edit the keyframe table and give no result. The front end
// decides in the accept cycle whether a request causes work and hands a command to a
// four-entry queue, so requests are taken at one per cycle until the queue fills. The
// back end runs one command at a time and pops the next only when idle: a progress value
// takes up to two passes of the shared one-bit-per-cycle divider plus the multiply steps,
// a keyframe value a sweep of the single-port table plus up to two divider passes.
// Config may be written only when the block is idle.
module timeline_signal_layer_evaluator_unit #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsle_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tsle_pkg::VALUE_W-1:0]        i_cfg_data,
    tsle_req_if.sink                            i_req,
    tsle_rsp_if.source                          o_rsp
);
    tsle_pkg::t_cfg  r_cfg;
    tsle_pkg::t_cmd  push_cmd;
    tsle_pkg::t_cmd  head_cmd;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    // config registers, to be written only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layer_mode   <= 1'b0;
            r_cfg.start_frame  <= '0;
            r_cfg.span_length  <= '0;
            r_cfg.value_source <= 1'b0;
            r_cfg.source_low   <= '0;
            r_cfg.source_high  <= tsle_pkg::ONE_Q16;
            r_cfg.target_low   <= '0;
            r_cfg.target_high  <= tsle_pkg::ONE_Q16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsle_pkg::CFG_LAYER_MODE:   r_cfg.layer_mode   <= i_cfg_data[0];
                tsle_pkg::CFG_START_FRAME:
                    r_cfg.start_frame <= i_cfg_data[tsle_pkg::FRAME_W-1:0];
                tsle_pkg::CFG_SPAN_LENGTH:
                    r_cfg.span_length <= i_cfg_data[tsle_pkg::FRAME_W-1:0];
                tsle_pkg::CFG_VALUE_SOURCE: r_cfg.value_source <= i_cfg_data[0];
                tsle_pkg::CFG_SOURCE_LOW:   r_cfg.source_low   <= signed'(i_cfg_data);
                tsle_pkg::CFG_SOURCE_HIGH:  r_cfg.source_high  <= signed'(i_cfg_data);
                tsle_pkg::CFG_TARGET_LOW:   r_cfg.target_low   <= signed'(i_cfg_data);
                tsle_pkg::CFG_TARGET_HIGH:  r_cfg.target_high  <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    tsle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    tsle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    tsle_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );
endmodule

/* tb/tb.sv */
// Self-checking testbench for timeline_signal_layer_evaluator_unit.
// Depends on tsle_pkg, tsle_req_if, tsle_rsp_if and the RTL top level.
module tb;

    typedef struct {
        logic [1:0]                   op;
        logic [tsle_pkg::FRAME_W-1:0] prev;
        logic [tsle_pkg::FRAME_W-1:0] cur;
        logic                         playing;
        logic                         brk;
        logic [tsle_pkg::FRAME_W-1:0] kpos;
        logic [tsle_pkg::VALUE_W-1:0] klev;
    } t_tick_req;

    localparam longint FMAX = 64'h7FFF_FFFF;
    localparam int     KEYS = 16;
    localparam int     DRAIN_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tsle_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tsle_pkg::VALUE_W-1:0] i_cfg_data = '0;

    tsle_req_if req_ch ();
    tsle_rsp_if rsp_ch ();

    timeline_signal_layer_evaluator_unit #(.MAX_KEYS(KEYS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_ch.sink),
        .o_rsp     (rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Layer model: shadow config and state
    // ---------------------------------------------------------------------
    bit     lay_mode;
    longint lay_start, lay_span;
    bit     lay_src;
    longint map_slo, map_shi, map_tlo, map_thi;

    longint key_pos [KEYS];
    longint key_lvl [KEYS];
    int     key_cnt;
    bit     armed;
    longint last_frame;
    bit     last_valid;

    bit     exp_kind [$];
    logic [tsle_pkg::VALUE_W-1:0] exp_value [$];
    t_tick_req pending [$];

    int  errors = 0;
    bit  calm = 1'b0;    // phase without idling on either side
    int  send_gap = 0;
    int  hold_cycles = 0;
    longint playhead;

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    task automatic add_pending(input t_tick_req r);
        pending.insert(pending.size(), r);
    endtask

    task automatic add_expect(input bit k, input logic [tsle_pkg::VALUE_W-1:0] v);
        exp_kind.insert(exp_kind.size(), k);
        exp_value.insert(exp_value.size(), v);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // linear interpolation over the table, local frame relative to start
    function automatic longint keyframe_level(input longint loc);
        int i;
        longint p0, p1, l0, l1, f;
        if (key_cnt == 0) return 0;
        if (loc <= key_pos[0]) return key_lvl[0];
        if (loc >= key_pos[key_cnt-1]) return key_lvl[key_cnt-1];
        i = 1;
        while (i < key_cnt - 1 && key_pos[i] < loc) i++;
        if (key_pos[i] == loc) return key_lvl[i];
        p0 = key_pos[i-1];
        p1 = key_pos[i];
        l0 = key_lvl[i-1];
        l1 = key_lvl[i];
        if (p1 <= p0 || loc < p0) return l0;
        f = ((loc - p0) << 16) / (p1 - p0);
        return l0 + ((l1 - l0) * f) / 65536;   // truncates toward zero
    endfunction

    function automatic longint clamp_map(input longint v);
        longint num, den, t, an, ad;
        if (map_shi == map_slo) return map_tlo;
        num = v - map_slo;
        den = map_shi - map_slo;
        if (num == 0 || ((num < 0) != (den < 0))) t = 0;
        else begin
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            t = (an >= ad) ? 65536 : (an << 16) / ad;
        end
        return map_tlo + (t * (map_thi - map_tlo)) / 65536;
    endfunction

    task automatic evaluate_layer(input t_tick_req r);
        longint cur, prev, raw;
        cur = r.cur;
        prev = r.prev;
        case (r.op)
            tsle_pkg::OP_APPEND: begin
                if (key_cnt < KEYS) begin
                    key_pos[key_cnt] = r.kpos;
                    key_lvl[key_cnt] = longint'($signed(r.klev));
                    key_cnt++;
                end
            end
            tsle_pkg::OP_CLEAR: key_cnt = 0;
            tsle_pkg::OP_TICK: begin
                if (!lay_mode) begin
                    if (cur < lay_start) armed = 1'b1;
                    if (r.playing && !r.brk && prev < lay_start && cur >= lay_start
                        && armed) begin
                        armed = 1'b0;
                        add_expect(1'b0, '0);
                    end
                end else if (cur >= lay_start && cur < lay_start + lay_span
                             && r.playing && !r.brk
                             && !(last_valid && last_frame == cur)) begin
                    last_frame = cur;
                    last_valid = 1'b1;
                    if (!lay_src) raw = ((cur - lay_start) << 16) / lay_span;
                    else raw = keyframe_level(cur - lay_start);
                    add_expect(1'b1, clamp_map(raw) & 64'hFFFF_FFFF);
                end
            end
            default: ;   // unused op: nothing happens
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending.size() > 0) begin
                t_tick_req r;
                r = pending.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.op             <= r.op;
                req_ch.previous_frame <= r.prev;
                req_ch.current_frame  <= r.cur;
                req_ch.is_playing     <= r.playing;
                req_ch.at_break       <= r.brk;
                req_ch.key_position   <= r.kpos;
                req_ch.key_level      <= r.klev;
                send_gap <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // request monitor: every accepted request updates the model
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_tick_req r;
            r.op = req_ch.op;
            r.prev = req_ch.previous_frame;
            r.cur = req_ch.current_frame;
            r.playing = req_ch.is_playing;
            r.brk = req_ch.at_break;
            r.kpos = req_ch.key_position;
            r.klev = req_ch.key_level;
            evaluate_layer(r);
        end
    end

    // result side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                hold_cycles <= pick_gap();
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (exp_kind.size() == 0) begin
                    report($sformatf("unexpected result kind %0b value %h",
                                     rsp_ch.emit_kind, rsp_ch.signal_value));
                end else begin
                    bit k;
                    logic [tsle_pkg::VALUE_W-1:0] v;
                    k = exp_kind.pop_front();
                    v = exp_value.pop_front();
                    if (rsp_ch.emit_kind !== k)
                        report($sformatf("emit_kind got %0b want %0b", rsp_ch.emit_kind, k));
                    if (rsp_ch.signal_value !== v)
                        report($sformatf("signal_value got %h want %h",
                                         rsp_ch.signal_value, v));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [tsle_pkg::CFG_IDX_W-1:0] idx, input longint val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[31:0];
        case (idx)
            tsle_pkg::CFG_LAYER_MODE:   lay_mode = val[0];
            tsle_pkg::CFG_START_FRAME:  lay_start = val & FMAX;
            tsle_pkg::CFG_SPAN_LENGTH:  lay_span = val & FMAX;
            tsle_pkg::CFG_VALUE_SOURCE: lay_src = val[0];
            tsle_pkg::CFG_SOURCE_LOW:   map_slo = longint'($signed(val[31:0]));
            tsle_pkg::CFG_SOURCE_HIGH:  map_shi = longint'($signed(val[31:0]));
            tsle_pkg::CFG_TARGET_LOW:   map_tlo = longint'($signed(val[31:0]));
            default:                    map_thi = longint'($signed(val[31:0]));
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender idles until every expected result is in and the back end is drained
    task automatic wait_quiet();
        while (pending.size() > 0 || req_ch.valid || exp_kind.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_tick_req mk(input logic [1:0] op, input longint prev,
                                     input longint cur, input bit play, input bit brk);
        t_tick_req r;
        r.op = op;
        r.prev = prev[30:0];
        r.cur = cur[30:0];
        r.playing = play;
        r.brk = brk;
        r.kpos = $urandom();
        r.klev = $urandom();
        return r;
    endfunction

    function automatic longint clip(input longint v);
        if (v < 0) return 0;
        if (v > FMAX) return FMAX;
        return v;
    endfunction

    task automatic push_key(input longint pos, input longint lvl);
        t_tick_req r;
        r = mk(tsle_pkg::OP_APPEND, $urandom(), $urandom(), $urandom(), $urandom());
        r.kpos = pos[30:0];
        r.klev = lvl[31:0];
        add_pending(r);
    endtask

    // random table: mostly sorted inside the span, sometimes unsorted or overfull
    task automatic build_table();
        int n;
        longint pos;
        longint top;
        bit sorted;
        add_pending(mk(tsle_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom()));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 8);
        sorted = $urandom_range(0, 9) != 0;
        top = (lay_span > 4000) ? 4000 : lay_span + 2;
        pos = 0;
        for (int i = 0; i < n; i++) begin
            if (sorted) pos = pos + $urandom_range(0, top / (n + 1) + 1);
            else pos = $urandom_range(0, top);
            push_key(pos, $urandom_range(0, 3) == 0 ? longint'($signed($urandom()))
                                                     : longint'($urandom_range(0, 300000)) - 100000);
        end
    endtask

    task automatic random_tick();
        int r;
        longint prev;
        t_tick_req t;
        prev = playhead;
        r = $urandom_range(0, 99);
        if (r < 70) playhead = clip(playhead + $urandom_range(0, 3));
        else if (r < 80) playhead = clip(lay_start - $urandom_range(0, 5));
        else if (r < 88) playhead = clip(lay_start + lay_span - $urandom_range(0, 3));
        else if (r < 94) playhead = clip(lay_start + $urandom_range(0, 40));
        else playhead = $urandom() & FMAX;
        t = mk(tsle_pkg::OP_TICK, prev, playhead, $urandom_range(0, 99) < 88,
               $urandom_range(0, 99) < 8);
        if ($urandom_range(0, 39) == 0) begin
            // noise: op and both frames fully random
            t.op = $urandom();
            t.prev = $urandom();
            t.cur = $urandom();
        end
        add_pending(t);
    endtask

    function automatic longint pick_frame();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return $urandom_range(1, 200);
            2: return FMAX - $urandom_range(0, 100);
            default: return $urandom() & FMAX;
        endcase
    endfunction

    function automatic longint pick_q16();
        case ($urandom_range(0, 5))
            0: return -2147483648;
            1: return 2147483647;
            2: return longint'($urandom_range(0, 400000)) - 200000;
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        req_ch.valid = 1'b0;
        req_ch.op = tsle_pkg::OP_TICK;
        req_ch.previous_frame = '0;
        req_ch.current_frame = '0;
        req_ch.is_playing = 1'b0;
        req_ch.at_break = 1'b0;
        req_ch.key_position = '0;
        req_ch.key_level = '0;
        rsp_ch.ready = 1'b0;
        lay_mode = 0; lay_start = 0; lay_span = 0; lay_src = 0;
        map_slo = 0; map_shi = 65536; map_tlo = 0; map_thi = 65536;
        key_cnt = 0; armed = 1'b1; last_frame = 0; last_valid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: momentary trigger around start 10, table ops, unused op
        write_reg(tsle_pkg::CFG_START_FRAME, 10);
        end_writes();
        add_pending(mk(tsle_pkg::OP_TICK, 5, 10, 1, 0));   // fires
        add_pending(mk(tsle_pkg::OP_TICK, 5, 12, 1, 0));   // disarmed
        add_pending(mk(tsle_pkg::OP_TICK, 12, 3, 1, 0));   // re-arm
        add_pending(mk(tsle_pkg::OP_TICK, 3, 12, 1, 1));   // at a break
        add_pending(mk(tsle_pkg::OP_TICK, 3, 12, 0, 0));   // stopped
        add_pending(mk(tsle_pkg::OP_TICK, 9, 11, 1, 0));   // fires
        add_pending(mk(2'd3, 0, 20, 1, 0));                // unused op
        add_pending(mk(tsle_pkg::OP_CLEAR, 0, 0, 0, 0));
        wait_quiet();

        // directed: continuous progress, then table with empty / full / exact hits
        write_reg(tsle_pkg::CFG_LAYER_MODE, 1);
        write_reg(tsle_pkg::CFG_SPAN_LENGTH, 50);
        end_writes();
        add_pending(mk(tsle_pkg::OP_TICK, 0, 10, 1, 0));
        add_pending(mk(tsle_pkg::OP_TICK, 10, 10, 1, 0)); // same frame, no result
        add_pending(mk(tsle_pkg::OP_TICK, 10, 59, 1, 0)); // last frame of span
        add_pending(mk(tsle_pkg::OP_TICK, 59, 60, 1, 0)); // past span
        wait_quiet();
        write_reg(tsle_pkg::CFG_VALUE_SOURCE, 1);
        write_reg(tsle_pkg::CFG_SOURCE_LOW, -65536);
        write_reg(tsle_pkg::CFG_SOURCE_HIGH, 131072);
        write_reg(tsle_pkg::CFG_TARGET_LOW, 2147483647);
        write_reg(tsle_pkg::CFG_TARGET_HIGH, -2147483648);
        end_writes();
        add_pending(mk(tsle_pkg::OP_TICK, 0, 20, 1, 0));  // empty table
        for (int i = 0; i < 17; i++) push_key(i * 3, i * 20000 - 150000);  // one too many
        add_pending(mk(tsle_pkg::OP_TICK, 20, 25, 1, 0)); // on a key
        add_pending(mk(tsle_pkg::OP_TICK, 25, 28, 1, 0)); // on a key
        add_pending(mk(tsle_pkg::OP_TICK, 28, 10, 1, 0)); // on the first key
        add_pending(mk(tsle_pkg::OP_TICK, 10, 59, 1, 0)); // past last key
        wait_quiet();

        // random phases over config settings, extremes included
        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph % 4 == 3);
            write_reg(tsle_pkg::CFG_LAYER_MODE, ($urandom_range(0, 3) != 0));
            write_reg(tsle_pkg::CFG_START_FRAME, (ph == 1) ? FMAX : pick_frame());
            write_reg(tsle_pkg::CFG_SPAN_LENGTH, (ph == 2) ? FMAX :
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                  : $urandom_range(2, 3000));
            write_reg(tsle_pkg::CFG_VALUE_SOURCE, $urandom_range(0, 1));
            if (ph == 4) begin
                write_reg(tsle_pkg::CFG_SOURCE_LOW, 4096);
                write_reg(tsle_pkg::CFG_SOURCE_HIGH, 4096);   // degenerate source range
            end else begin
                write_reg(tsle_pkg::CFG_SOURCE_LOW, pick_q16());
                write_reg(tsle_pkg::CFG_SOURCE_HIGH, pick_q16());
            end
            write_reg(tsle_pkg::CFG_TARGET_LOW, pick_q16());
            write_reg(tsle_pkg::CFG_TARGET_HIGH, pick_q16());
            end_writes();
            playhead = clip(lay_start - $urandom_range(0, 4));
            for (int n = 0; n < 75; n++) begin
                if ($urandom_range(0, 24) == 0) build_table();
                else random_tick();
            end
            wait_quiet();
        end
        calm = 1'b0;

        if (errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        #12000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
